/* hw/rtl/ps2mc_pkg.sv */
// Package for the PS/2 mouse cursor tracker: widths, codes, shared structs.
// No dependencies; every other file imports it.
package ps2mc_pkg;

  localparam int COORD_BITS  = 12;   // stored cursor position width
  localparam int SIZE_BITS   = 12;   // screen size register width
  localparam int OUT_XY_BITS = 12;   // cursor fields of an event beat
  localparam int WORK_BITS   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
  localparam int CFG_IDX_BITS = 2;

  localparam int DELTA_SPAN  = 256;  // two's complement span of a delta byte
  localparam int BOUND_BACK  = 2;    // overshoot lands at size - 2
  localparam logic [7:0] BTN_MASK = 8'h07;

  localparam logic [SIZE_BITS-1:0] WIDTH_RST  = SIZE_BITS'(640);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RST = SIZE_BITS'(480);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t_t;

  typedef enum logic [1:0] {
    EV_WHEEL = 2'd0,
    EV_CLICK = 2'd1,
    EV_MOVE  = 2'd2
  } ev_kind_t;

  // pending event mask, bit order is emission order
  typedef struct packed {
    logic move;
    logic click;
    logic wheel;
  } ev_mask_t;

  typedef struct packed {
    logic [2:0]        buttons;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic signed [7:0] wheel;
  } report_t;

  // one report handed from the input stage to the event sequencer
  typedef struct packed {
    ev_mask_t mask;
    report_t  rep;
    coord_t   old_x;
    coord_t   old_y;
    coord_t   new_x;
    coord_t   new_y;
  } seq_load_t;

endpackage

/* hw/rtl/ps2mc_ifs.sv */
// Valid/ready channel interfaces for reports in and events out.
// Depends on ps2mc_pkg for widths.
interface ps2mc_rep_if;
  import ps2mc_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        status_byte;
  logic [7:0]        delta_x;
  logic [7:0]        delta_y;
  logic signed [7:0] wheel_delta;

  modport source (output valid, status_byte, delta_x, delta_y, wheel_delta, input ready);
  modport sink   (input valid, status_byte, delta_x, delta_y, wheel_delta, output ready);
endinterface

interface ps2mc_evt_if;
  import ps2mc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             event_kind;
  logic [OUT_XY_BITS-1:0] cursor_x;
  logic [OUT_XY_BITS-1:0] cursor_y;
  logic [2:0]             button_bits;
  logic signed [7:0]      wheel_amount;
  logic [7:0]             raw_dx;
  logic [7:0]             raw_dy;
  logic                   last_event;

  modport source (output valid, event_kind, cursor_x, cursor_y, button_bits,
                  wheel_amount, raw_dx, raw_dy, last_event, input ready);
  modport sink   (input valid, event_kind, cursor_x, cursor_y, button_bits,
                  wheel_amount, raw_dx, raw_dy, last_event, output ready);
endinterface

/* hw/rtl/ps2mc_axis.sv */
// One cursor axis: apply a delta byte, clamp at 0 or at the screen bound.
// Depends on ps2mc_pkg.
module ps2mc_axis
  import ps2mc_pkg::*;
(
  input  coord_t     pos_i,
  input  size_t_t    size_i,
  input  logic [7:0] delta_i,
  input  logic       grow_i,   // step toward the upper bound
  output coord_t     pos_o
);

  logic [8:0]           mag;
  logic [WORK_BITS-1:0] pos_w;
  logic [WORK_BITS-1:0] sum_w;
  logic [WORK_BITS-1:0] dif_w;
  logic [SIZE_BITS-1:0] bound;

  always_comb begin
    // magnitude of the two's complement byte
    if (delta_i[7]) begin
      mag = 9'(DELTA_SPAN) - {1'b0, delta_i};
    end else begin
      mag = {1'b0, delta_i};
    end
    pos_w = WORK_BITS'(pos_i);
    sum_w = pos_w + WORK_BITS'(mag);
    dif_w = pos_w - WORK_BITS'(mag);
    bound = (size_i >= SIZE_BITS'(BOUND_BACK)) ? size_i - SIZE_BITS'(BOUND_BACK) : '0;

    if (grow_i) begin
      if (sum_w > WORK_BITS'(size_i)) begin
        pos_o = COORD_BITS'(bound);
      end else begin
        pos_o = COORD_BITS'(sum_w);
      end
    end else begin
      // sign bit of the difference: went below zero
      if (dif_w[WORK_BITS-1]) begin
        pos_o = '0;
      end else begin
        pos_o = COORD_BITS'(dif_w);
      end
    end
  end

endmodule

/* hw/rtl/ps2mc_event_seq.sv */
// Event sequencer: holds one report and emits its events, one beat a cycle
// unless out_ch stalls, via the output register. Depends on ps2mc_pkg, ps2mc_evt_if.
module ps2mc_event_seq
  import ps2mc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  seq_load_t  load_data_i,
  output logic       free_o,
  ps2mc_evt_if.source out_ch
);

  logic      seq_vld_r;
  seq_load_t seq_r;
  ev_mask_t  pend_r;
  ev_mask_t  pend_nxt;
  ev_mask_t  cur;
  logic      emit;
  logic      last;

  logic                   out_vld_r;
  ev_kind_t               kind_r;
  logic [OUT_XY_BITS-1:0] x_r;
  logic [OUT_XY_BITS-1:0] y_r;
  logic [2:0]             btn_r;
  logic signed [7:0]      whl_r;
  logic [7:0]             dx_r;
  logic [7:0]             dy_r;
  logic                   last_r;

  always_comb begin
    cur = '0;
    if (pend_r.wheel) begin
      cur.wheel = 1'b1;
    end else if (pend_r.click) begin
      cur.click = 1'b1;
    end else begin
      cur.move = pend_r.move;
    end
    pend_nxt = pend_r & ~cur;
    last     = (pend_nxt == '0);
    emit     = seq_vld_r && (!out_vld_r || out_ch.ready);
    free_o   = !seq_vld_r || (emit && last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_vld_r <= 1'b0;
      pend_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (load_i) begin
        seq_vld_r <= 1'b1;
        pend_r    <= load_data_i.mask;
      end else if (emit) begin
        seq_vld_r <= !last;
        pend_r    <= pend_nxt;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (load_i) begin
      seq_r <= load_data_i;
    end
    if (emit) begin
      last_r <= last;
      if (cur.wheel) begin
        kind_r <= EV_WHEEL;
        x_r    <= OUT_XY_BITS'(seq_r.old_x);
        y_r    <= OUT_XY_BITS'(seq_r.old_y);
        btn_r  <= '0;
        whl_r  <= seq_r.rep.wheel;
        dx_r   <= '0;
        dy_r   <= '0;
      end else if (cur.click) begin
        kind_r <= EV_CLICK;
        x_r    <= OUT_XY_BITS'(seq_r.old_x);
        y_r    <= OUT_XY_BITS'(seq_r.old_y);
        btn_r  <= seq_r.rep.buttons;
        whl_r  <= '0;
        dx_r   <= '0;
        dy_r   <= '0;
      end else begin
        kind_r <= EV_MOVE;
        x_r    <= OUT_XY_BITS'(seq_r.new_x);
        y_r    <= OUT_XY_BITS'(seq_r.new_y);
        btn_r  <= '0;
        whl_r  <= '0;
        dx_r   <= seq_r.rep.dx;
        dy_r   <= seq_r.rep.dy;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_kind   = kind_r;
  assign out_ch.cursor_x     = x_r;
  assign out_ch.cursor_y     = y_r;
  assign out_ch.button_bits  = btn_r;
  assign out_ch.wheel_amount = whl_r;
  assign out_ch.raw_dx       = dx_r;
  assign out_ch.raw_dy       = dy_r;
  assign out_ch.last_event   = last_r;

  a_busy_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    seq_vld_r |-> (pend_r != '0))
    else $error("sequencer busy with no pending event");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> (free_o && load_data_i.mask != '0))
    else $error("report loaded into a busy sequencer or with no events");

  a_emit_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> $onehot(cur))
    else $error("emitted beat does not select exactly one event");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last && !load_i) |=> !seq_vld_r)
    else $error("sequencer still busy after its last event");

endmodule

/* hw/rtl/ps2_mouse_cursor_tracker.sv */
// Top level of the PS/2 mouse cursor tracker: input register, cursor state,
// screen size registers. Depends on ps2mc_pkg, ps2mc_ifs, ps2mc_axis, ps2mc_event_seq.
//
//   channel  | dir | handshake          | beat
//   ---------+-----+--------------------+------------------------------------------
//   in_ch    | in  | valid/ready        | one decoded report: status, dx, dy, wheel
//   out_ch   | out | valid/ready        | one event: kind, cursor, buttons, wheel, deltas
//   cfg_*    | in  | cfg_we, no ready   | screen width (index 0) / height (index 1)
//
// A report beat lands in the input register; once the sequencer is free it moves
// into the event sequencer and a moving report updates the cursor; events leave
// one per cycle from the output register unless out_ch stalls, so the sequencer
// holds a report until its 1 to 3 events are out, and a report with no events
// drops straight out of the input register without entering the sequencer.
// Reset is synchronous, active low: cursor to (0,0), size to 640 x 480.
// A stall on out_ch holds the output register and backs up into in_ch.ready.
module ps2_mouse_cursor_tracker
  import ps2mc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  ps2mc_rep_if.sink               in_ch,
  ps2mc_evt_if.source             out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data
);

  size_t_t   width_r;
  size_t_t   height_r;
  coord_t    pos_x_r;
  coord_t    pos_y_r;
  coord_t    new_x;
  coord_t    new_y;

  logic      in_vld_r;
  report_t   in_r;
  ev_mask_t  mask;
  logic      mv;
  logic      seq_free;
  logic      load;
  seq_load_t load_data;

  // Hold a report in the input register until the sequencer takes it.
  always_comb begin
    mask.wheel = (in_r.wheel != '0);
    mask.click = (in_r.buttons != '0);
    mask.move  = (in_r.dx != '0) || (in_r.dy != '0);
    // a report with no events drops straight out of the input register
    mv   = in_vld_r && ((mask == '0) || seq_free);
    load = mv && (mask != '0);
    load_data.mask  = mask;
    load_data.rep   = in_r;
    load_data.old_x = pos_x_r;
    load_data.old_y = pos_y_r;
    load_data.new_x = new_x;
    load_data.new_y = new_y;
  end

  assign in_ch.ready = !in_vld_r || mv;

  // X grows for a non-negative byte; Y is inverted, so a negative byte grows it.
  ps2mc_axis u_axis_x (
    .pos_i   (pos_x_r),
    .size_i  (width_r),
    .delta_i (in_r.dx),
    .grow_i  (!in_r.dx[7]),
    .pos_o   (new_x)
  );

  ps2mc_axis u_axis_y (
    .pos_i   (pos_y_r),
    .size_i  (height_r),
    .delta_i (in_r.dy),
    .grow_i  (in_r.dy[7]),
    .pos_o   (new_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (mv) begin
        in_vld_r <= 1'b0;
      end
      // advance the cursor only on a report that moves
      if (load && mask.move) begin
        pos_x_r <= new_x;
        pos_y_r <= new_y;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
          CFG_SCREEN_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.buttons <= in_ch.status_byte[2:0] & BTN_MASK[2:0];
      in_r.dx      <= in_ch.delta_x;
      in_r.dy      <= in_ch.delta_y;
      in_r.wheel   <= in_ch.wheel_delta;
    end
  end

  ps2mc_event_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .load_data_i (load_data),
    .free_o      (seq_free),
    .out_ch      (out_ch)
  );

  a_still_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && mask.move) |=> ($stable(pos_x_r) && $stable(pos_y_r)))
    else $error("cursor changed without a moving report");

  a_full_in_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !mv) |-> !in_ch.ready)
    else $error("input register overwritten while still held");

  a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load && mask.move && in_r.dx[7]) |-> (new_x <= pos_x_r))
    else $error("leftward move increased cursor x");

endmodule

/* sim/ps2_mouse_cursor_tracker_checker.sv */
`timescale 1ns / 100ps
// Checker for the PS/2 mouse cursor tracker: follows size writes and report beats,
// keeps its own cursor, and compares every event beat with the oldest one owed.
// Depends on ps2mc_pkg and the ps2mc_ifs channel interfaces.
module ps2_mouse_cursor_tracker_checker
  import ps2mc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  ps2mc_rep_if                    rep,
  ps2mc_evt_if                    evt,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data,
  output int                      mismatch_count,
  output int                      events_owed
);

  typedef struct {
    ev_kind_t          kind;
    coord_t            x;
    coord_t            y;
    logic [2:0]        buttons;
    logic signed [7:0] wheel;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic              last;
  } cursor_event_t;

  coord_t        track_x;
  coord_t        track_y;
  size_t_t       bound_w;
  size_t_t       bound_h;
  cursor_event_t owed_events[$];

  // landing spot past the far edge; a size below two lands on zero
  function automatic int overshoot_to(size_t_t size);
    return (int'(size) < BOUND_BACK) ? 0 : int'(size) - BOUND_BACK;
  endfunction

  function automatic void queue_event(ev_kind_t kind, logic [2:0] buttons,
                                      logic signed [7:0] wheel, logic [7:0] dx,
                                      logic [7:0] dy, logic last);
    cursor_event_t ev;
    ev.kind    = kind;
    ev.x       = track_x;
    ev.y       = track_y;
    ev.buttons = buttons;
    ev.wheel   = wheel;
    ev.dx      = dx;
    ev.dy      = dy;
    ev.last    = last;
    owed_events.insert(owed_events.size(), ev);
  endfunction

  function automatic void apply_report(logic [7:0] status, logic [7:0] dx,
                                       logic [7:0] dy, logic signed [7:0] wheel);
    logic clicked;
    logic moving;
    int   nx;
    int   ny;
    clicked = (status & BTN_MASK) != 8'd0;
    moving  = (dx != 8'd0) || (dy != 8'd0);
    if (wheel != 8'sd0)
      queue_event(EV_WHEEL, 3'd0, wheel, 8'd0, 8'd0, !(clicked || moving));
    if (clicked)
      queue_event(EV_CLICK, status[2:0], 8'sd0, 8'd0, 8'd0, !moving);
    if (moving) begin
      nx = int'(track_x);
      ny = int'(track_y);
      // top bit set means a negative step; screen y runs opposite to raw y
      if (dx[7]) begin
        nx -= DELTA_SPAN - int'(dx);
        if (nx < 0) nx = 0;
      end else begin
        nx += int'(dx);
        if (nx > int'(bound_w)) nx = overshoot_to(bound_w);
      end
      if (dy[7]) begin
        ny += DELTA_SPAN - int'(dy);
        if (ny > int'(bound_h)) ny = overshoot_to(bound_h);
      end else begin
        ny -= int'(dy);
        if (ny < 0) ny = 0;
      end
      track_x = coord_t'(nx);
      track_y = coord_t'(ny);
      queue_event(EV_MOVE, 3'd0, 8'sd0, dx, dy, 1'b1);
    end
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    cursor_event_t want;
    if (!rst_n) begin
      track_x = '0;
      track_y = '0;
      bound_w = WIDTH_RST;
      bound_h = HEIGHT_RST;
      owed_events.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_WIDTH) bound_w = cfg_data;
        else if (cfg_index == CFG_SCREEN_HEIGHT) bound_h = cfg_data;
      end
      if (rep.valid && rep.ready)
        apply_report(rep.status_byte, rep.delta_x, rep.delta_y, rep.wheel_delta);
      if (evt.valid && evt.ready) begin
        if (owed_events.size() == 0) begin
          $error("event beat with nothing owed: kind %0d at (%0d,%0d)",
                 evt.event_kind, evt.cursor_x, evt.cursor_y);
          mismatch_count++;
        end else begin
          want = owed_events.pop_front();
          check_field("event_kind", int'(want.kind), int'(evt.event_kind));
          check_field("cursor_x", int'(want.x), int'(evt.cursor_x));
          check_field("cursor_y", int'(want.y), int'(evt.cursor_y));
          check_field("button_bits", int'(want.buttons), int'(evt.button_bits));
          check_field("wheel_amount", int'(want.wheel), int'(evt.wheel_amount));
          check_field("raw_dx", int'(want.dx), int'(evt.raw_dx));
          check_field("raw_dy", int'(want.dy), int'(evt.raw_dy));
          check_field("last_event", int'(want.last), int'(evt.last_event));
        end
      end
    end
    events_owed <= owed_events.size();
  end

endmodule

/* sim/ps2_mouse_cursor_tracker_test.sv */
`timescale 1ns / 100ps
// Top of the cursor tracker testbench: clock, reset, report and size stimulus,
// event-side back-pressure and the verdict. Depends on ps2mc_pkg, ps2mc_ifs,
// the tracker RTL and ps2_mouse_cursor_tracker_checker.
module ps2_mouse_cursor_tracker_test;
  import ps2mc_pkg::*;

  logic                    clk   = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]    cfg_data;
  int                      mismatch_count;
  int                      events_owed;

  // knobs for the report driver and the event-side receiver; idle_en is shared by both
  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  ps2mc_rep_if in_ch();
  ps2mc_evt_if out_ch();

  ps2_mouse_cursor_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ps2_mouse_cursor_tracker_checker tracker_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .rep            (in_ch),
    .evt            (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .events_owed    (events_owed)
  );

  always #2 clk = ~clk;

  // Offer one report beat and hold it until the tracker takes it. Valid stays
  // high into the next beat unless, with idle_en set, a random gap drops it.
  task automatic send_report(input logic [7:0] status, input logic [7:0] dx,
                             input logic [7:0] dy, input logic signed [7:0] wheel);
    in_ch.valid       <= 1'b1;
    in_ch.status_byte <= status;
    in_ch.delta_x     <= dx;
    in_ch.delta_y     <= dy;
    in_ch.wheel_delta <= wheel;
    do @(posedge clk); while (!in_ch.ready);
    if (idle_en && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
  endtask

  // Drop valid, wait for every owed event to come out, then wait on so that the
  // block can retire reports that cause no event at all.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (events_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  // Write the width register, then the height register; call only when idle.
  task automatic set_screen(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Favor zero and small steps (1 to 8 counts either way) so the cursor hugs the screen edges.
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return $urandom_range(1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(248, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random reports. With drift set, push the cursor right and down on every
  // report so that even a full-size screen reaches its far edges.
  task automatic run_random(input int count, input bit drift);
    logic [7:0]        status;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic signed [7:0] wheel;
    repeat (count) begin
      status = 8'($urandom_range(0, 255));
      if ($urandom_range(3) == 0) status[2:0] = 3'd0;
      if (drift) begin
        dx = 8'($urandom_range(64, 127));
        dy = 8'($urandom_range(128, 192));
      end else begin
        dx = pick_delta();
        dy = pick_delta();
      end
      wheel = $urandom_range(1) ? 8'sd0 : 8'($urandom_range(0, 255));
      // now and then a report that raises no event at all
      if ($urandom_range(9) == 0) begin
        status[2:0] = 3'd0;
        dx          = 8'd0;
        dy          = 8'd0;
        wheel       = 8'sd0;
      end
      send_report(status, dx, dy, wheel);
    end
  endtask

  // Event-side receiver: random back-pressure, plus one long hold-off on
  // request that lets the tracker fill up and stall its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(idle_en && $urandom_range(99) < 33);
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.status_byte = 8'd0;
    in_ch.delta_x     = 8'd0;
    in_ch.delta_y     = 8'd0;
    in_ch.wheel_delta = 8'sd0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SCREEN_WIDTH;
    cfg_data          = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size 640 x 480, cursor at the origin.
    send_report(8'hF8, 8'h00, 8'h00, 8'sh00);   // upper status bits only: no event
    send_report(8'h00, 8'h00, 8'h00, 8'sh7F);   // wheel extremes
    send_report(8'h00, 8'h00, 8'h00, 8'sh80);
    send_report(8'h01, 8'h00, 8'h00, 8'sh00);   // each button, then all of them
    send_report(8'h02, 8'h00, 8'h00, 8'sh00);
    send_report(8'h04, 8'h00, 8'h00, 8'sh00);
    send_report(8'hFF, 8'h00, 8'h00, 8'sh00);
    send_report(8'h00, 8'h7F, 8'h00, 8'sh00);   // largest step right
    send_report(8'h00, 8'h80, 8'h00, 8'sh00);   // largest step left, clamps at 0
    send_report(8'h00, 8'h00, 8'h80, 8'sh00);   // largest step down
    send_report(8'h00, 8'h00, 8'h7F, 8'sh00);   // largest step up
    send_report(8'h07, 8'hFF, 8'h01, 8'shFD);   // wheel, click and move together

    // Small screen: land exactly on each edge, then one past it.
    settle();
    set_screen(12'd100, 12'd50);
    send_report(8'h00, 8'd100, 8'h00, 8'sh00);
    send_report(8'h00, 8'h01, 8'h00, 8'sh00);
    send_report(8'h00, 8'h00, 8'hCE, 8'sh00);
    send_report(8'h00, 8'h00, 8'hFF, 8'sh00);

    // Shrink under the cursor: a still report keeps the stale spot, a move on y
    // alone pulls x back inside, and a move on x alone leaves a stale y as it is.
    settle();
    set_screen(12'd10, 12'd10);
    send_report(8'h02, 8'h00, 8'h00, 8'sh00);
    send_report(8'h00, 8'h00, 8'h01, 8'sh00);
    send_report(8'h00, 8'h01, 8'h00, 8'sh00);

    // Sizes below two: the overshoot target holds at zero.
    settle();
    set_screen(12'd1, 12'd0);
    send_report(8'h00, 8'h05, 8'h80, 8'sh00);
    send_report(8'h00, 8'h7F, 8'h81, 8'sh00);

    // Largest screen, drifting toward the far corner.
    settle();
    set_screen(12'd4095, 12'd4095);
    run_random(100, 1'b1);

    // Smallest legal screen.
    settle();
    set_screen(12'd2, 12'd2);
    run_random(60, 1'b0);

    // Random mid-size screens; the last one runs without idling on either
    // side and with one long stall on the event side.
    settle();
    set_screen(SIZE_BITS'($urandom_range(2, 300)), SIZE_BITS'($urandom_range(2, 300)));
    run_random(80, 1'b0);
    settle();
    set_screen(SIZE_BITS'($urandom_range(2, 300)), SIZE_BITS'($urandom_range(2, 300)));
    run_random(80, 1'b0);
    settle();
    set_screen(SIZE_BITS'($urandom_range(2, 300)), SIZE_BITS'($urandom_range(2, 300)));
    idle_en  = 1'b0;
    hold_req = 1'b1;
    run_random(80, 1'b0);

    settle();
    if (mismatch_count == 0 && events_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
